// ===== design/pler_pkg.sv =====
// pler_pkg: shared constants, codes and types of the pinned lru expert cache
// no dependencies
package pler_pkg;

  localparam int DEF_EXPERT_COUNT = 64;
  localparam int DEF_PIN_BITS     = 8;

  localparam int ACT_W  = 3;
  localparam int EIDX_W = 8;
  localparam int CODE_W = 4;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [ACT_W-1:0] ACT_PREFETCH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ACQUIRE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOAD_DONE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_EVICT_DONE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TRIM       = 3'd5;

  localparam logic [CODE_W-1:0] RC_OK        = 4'd0;
  localparam logic [CODE_W-1:0] RC_MISS      = 4'd1;
  localparam logic [CODE_W-1:0] RC_BUSY      = 4'd2;
  localparam logic [CODE_W-1:0] RC_FAILED    = 4'd3;
  localparam logic [CODE_W-1:0] RC_RANGE     = 4'd4;
  localparam logic [CODE_W-1:0] RC_UNDERFLOW = 4'd5;
  localparam logic [CODE_W-1:0] RC_IGNORED   = 4'd6;
  localparam logic [CODE_W-1:0] RC_NOTHING   = 4'd7;
  localparam logic [CODE_W-1:0] RC_PIN_SAT   = 4'd8;

  localparam logic [ST_W-1:0] ST_UNLOADED = 3'd0;
  localparam logic [ST_W-1:0] ST_LOADING  = 3'd1;
  localparam logic [ST_W-1:0] ST_RESIDENT = 3'd2;
  localparam logic [ST_W-1:0] ST_EVICTING = 3'd3;
  localparam logic [ST_W-1:0] ST_FAILED   = 3'd4;

  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_REGISTERED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PICK = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  typedef struct packed {
    logic rm;
    logic app;
    logic dec;
  } cell_ctl_t;

endpackage

// ===== design/pler_ram.sv =====
// pler_ram: generic single-port ram with registered read
// no dependencies
module pler_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pler_cell.sv =====
// pler_cell: one position of the recency list, holds expert id and pin count
// depends on pler_pkg
module pler_cell import pler_pkg::*; #(
  parameter int IW  = 6,
  parameter int PW  = 8,
  parameter int LW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic          mask_i,
  input  logic          sel_i,
  input  logic [LW-1:0] app_pos_i,
  input  logic [IW-1:0] app_id_i,
  input  logic [PW-1:0] app_pin_i,
  input  logic [IW-1:0] key_i,
  input  logic          nxt_valid_i,
  input  logic [IW-1:0] nxt_id_i,
  input  logic [PW-1:0] nxt_pin_i,
  output logic          valid_o,
  output logic [IW-1:0] id_o,
  output logic [PW-1:0] pin_o,
  output logic          match_o,
  output logic          cand_o
);

  logic          valid_q, valid_d;
  logic [IW-1:0] id_q, id_d;
  logic [PW-1:0] pin_q, pin_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    pin_d   = pin_q;
    if (ctl_i.app && (app_pos_i == LW'(IDX))) begin
      valid_d = 1'b1;
      id_d    = app_id_i;
      pin_d   = app_pin_i;
    end else if (ctl_i.rm && mask_i) begin
      valid_d = nxt_valid_i;
      id_d    = nxt_id_i;
      pin_d   = nxt_pin_i;
    end else if (ctl_i.dec && sel_i) begin
      pin_d = pin_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    pin_q <= pin_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign pin_o   = pin_q;
  assign match_o = valid_q && (id_q == key_i);
  assign cand_o  = valid_q && (pin_q == '0);

endmodule

// ===== design/pinned_lru_expert_cache.sv =====
// pinned_lru_expert_cache: top level, sequencer, status table and recency cell chain
// depends on pler_pkg, pler_ram, pler_cell
//
//   channel   handshake          payload
//   command   start_i / busy_o   action_i, expert_index_i, op_ok_i
//   result    done_o (strobe)    status_code_o .. resident_count_o
//   config    apb psel/penable   paddr, pwdata, prdata
//
// every word passes through accept, status read and list match, select and update
// the result strobe comes the cycle after the update, when busy_o is already low
// the status ram read and the one-hot select of the cell chain are registered steps
// reset empties the list and marks every expert unloaded at once
// results cannot be stalled
module pinned_lru_expert_cache import pler_pkg::*; #(
  parameter int EXPERT_COUNT = DEF_EXPERT_COUNT,
  parameter int PIN_BITS     = DEF_PIN_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [EIDX_W-1:0] expert_index_i,
  input  logic              op_ok_i,
  output logic              done_o,
  output logic [CODE_W-1:0] status_code_o,
  output logic              load_request_o,
  output logic              evict_request_o,
  output logic [EIDX_W-1:0] target_expert_o,
  output logic              expert_miss_o,
  output logic [CNT_W-1:0]  resident_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int N    = EXPERT_COUNT;
  localparam int IW   = $clog2(N);
  localparam int PW   = PIN_BITS;
  localparam int LW   = $clog2(N + 1);
  localparam int CMPW = (LW > CNT_W) ? LW : CNT_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cap_q;
  logic              reg_q;
  logic [ACT_W-1:0]  act_q;
  logic [EIDX_W-1:0] e_q;
  logic              ok_q;
  logic [ST_W-1:0]   st_q;
  logic [N-1:0]      stv_q;
  logic [N-1:0]      hit_q, cand_q, sel_q;
  logic [LW-1:0]     len_q, len_d;

  logic [ST_W-1:0]   ram_rdata, st_wd;
  logic [IW-1:0]     ram_addr, st_wa;
  logic              st_we;

  logic [N-1:0]      c_valid, c_match, c_cand, mask, n_valid;
  logic [IW-1:0]     c_id [N];
  logic [IW-1:0]     n_id [N];
  logic [PW-1:0]     c_pin [N];
  logic [PW-1:0]     n_pin [N];

  cell_ctl_t         ctl;
  logic [LW-1:0]     app_pos;
  logic [PW-1:0]     app_pin;
  logic              rm_real;

  logic [CODE_W-1:0] code;
  logic              load, evict, miss;
  logic [EIDX_W-1:0] tgt;

  logic [CODE_W-1:0] code_q;
  logic              load_q, evict_q, miss_q, done_q;
  logic [EIDX_W-1:0] tgt_q;

  logic              accept, in_range, hit;
  logic [IW-1:0]     e_id, sel_id;
  logic [PW-1:0]     sel_pin;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != S_IDLE);
  assign e_id     = e_q[IW-1:0];
  assign in_range = ({1'b0, e_q} < 9'(N));

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_CAPACITY:   prdata = {25'd0, cap_q};
      REG_REGISTERED: prdata = {31'd0, reg_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      reg_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_CAPACITY) begin
        cap_q <= pwdata[CNT_W-1:0];
      end else begin
        reg_q <= pwdata[0];
      end
    end
  end

  // status table
  assign ram_addr = (state_q == S_EXEC) ? st_wa : expert_index_i[IW-1:0];

  pler_ram #(.W(ST_W), .D(N)) u_status (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (ram_addr),
    .wdata_i (st_wd),
    .rdata_o (ram_rdata)
  );

  // recency cell chain
  assign mask = ~(sel_q - 1'b1);

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign n_valid[i] = 1'b0;
      assign n_id[i]    = '0;
      assign n_pin[i]   = '0;
    end else begin : g_mid
      assign n_valid[i] = c_valid[i+1];
      assign n_id[i]    = c_id[i+1];
      assign n_pin[i]   = c_pin[i+1];
    end
    pler_cell #(.IW(IW), .PW(PW), .LW(LW), .IDX(i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .mask_i      (mask[i]),
      .sel_i       (sel_q[i]),
      .app_pos_i   (app_pos),
      .app_id_i    (e_id),
      .app_pin_i   (app_pin),
      .key_i       (e_id),
      .nxt_valid_i (n_valid[i]),
      .nxt_id_i    (n_id[i]),
      .nxt_pin_i   (n_pin[i]),
      .valid_o     (c_valid[i]),
      .id_o        (c_id[i]),
      .pin_o       (c_pin[i]),
      .match_o     (c_match[i]),
      .cand_o      (c_cand[i])
    );
  end

  always_comb begin
    sel_id  = '0;
    sel_pin = '0;
    for (int i = 0; i < N; i++) begin
      if (sel_q[i]) begin
        sel_id  = sel_id | c_id[i];
        sel_pin = sel_pin | c_pin[i];
      end
    end
  end

  assign hit = |sel_q;

  // event decode
  always_comb begin
    code    = RC_IGNORED;
    load    = 1'b0;
    evict   = 1'b0;
    miss    = 1'b0;
    tgt     = '0;
    st_we   = 1'b0;
    st_wd   = ST_UNLOADED;
    st_wa   = e_id;
    ctl     = '0;
    app_pin = '0;
    case (act_q)
      ACT_PREFETCH: begin
        if (!reg_q) begin
          code = RC_IGNORED;
        end else if (!in_range) begin
          code = RC_RANGE;
        end else begin
          case (st_q)
            ST_EVICTING: code = RC_BUSY;
            ST_UNLOADED: begin
              st_we = 1'b1;
              st_wd = ST_LOADING;
              load  = 1'b1;
              tgt   = e_q;
              code  = RC_MISS;
            end
            ST_RESIDENT: begin
              ctl.rm  = 1'b1;
              ctl.app = 1'b1;
              app_pin = sel_pin;
              code    = RC_OK;
            end
            ST_LOADING: code = RC_MISS;
            default:    code = RC_FAILED;
          endcase
        end
      end
      ACT_ACQUIRE: begin
        if (!reg_q || !in_range) begin
          code = RC_RANGE;
        end else begin
          case (st_q)
            ST_LOADING, ST_EVICTING: begin
              code = RC_BUSY;
              miss = 1'b1;
            end
            ST_UNLOADED: begin
              st_we = 1'b1;
              st_wd = ST_LOADING;
              load  = 1'b1;
              tgt   = e_q;
              code  = RC_MISS;
              miss  = 1'b1;
            end
            ST_RESIDENT: begin
              ctl.rm  = 1'b1;
              ctl.app = 1'b1;
              if (&sel_pin) begin
                app_pin = sel_pin;
                code    = RC_PIN_SAT;
              end else begin
                app_pin = sel_pin + 1'b1;
                code    = RC_OK;
              end
            end
            default: code = RC_FAILED;
          endcase
        end
      end
      ACT_RELEASE: begin
        if (!in_range) begin
          code = RC_RANGE;
        end else if (!hit || (sel_pin == '0)) begin
          code = RC_UNDERFLOW;
        end else begin
          ctl.dec = 1'b1;
          code    = RC_OK;
        end
      end
      ACT_LOAD_DONE: begin
        if (!in_range) begin
          code = RC_RANGE;
        end else if (st_q != ST_LOADING) begin
          code = RC_IGNORED;
        end else if (ok_q) begin
          st_we   = 1'b1;
          st_wd   = ST_RESIDENT;
          ctl.rm  = 1'b1;
          ctl.app = 1'b1;
          code    = RC_OK;
        end else begin
          st_we = 1'b1;
          st_wd = ST_FAILED;
          code  = RC_FAILED;
        end
      end
      ACT_EVICT_DONE: begin
        if (!in_range) begin
          code = RC_RANGE;
        end else if (st_q != ST_EVICTING) begin
          code = RC_IGNORED;
        end else begin
          st_we = 1'b1;
          st_wd = ok_q ? ST_UNLOADED : ST_FAILED;
          code  = ok_q ? RC_OK : RC_FAILED;
        end
      end
      ACT_TRIM: begin
        code = RC_NOTHING;
        if ((CMPW'(len_q) > CMPW'(cap_q)) && hit) begin
          ctl.rm = 1'b1;
          st_we  = 1'b1;
          st_wa  = sel_id;
          st_wd  = ST_EVICTING;
          evict  = 1'b1;
          tgt    = EIDX_W'(sel_id);
          code   = RC_OK;
        end
      end
      default: code = RC_IGNORED;
    endcase
    if (state_q != S_EXEC) begin
      st_we = 1'b0;
      ctl   = '0;
    end
  end

  assign rm_real = ctl.rm && hit;
  assign app_pos = len_q - LW'(rm_real);
  assign len_d   = app_pos + LW'(ctl.app);

  // sequencer
  always_comb begin
    case (state_q)
      S_IDLE:  state_d = accept ? S_SCAN : S_IDLE;
      S_SCAN:  state_d = S_PICK;
      S_PICK:  state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stv_q   <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
      if (state_q == S_EXEC) begin
        len_q <= len_d;
        if (st_we) begin
          stv_q[st_wa] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      e_q   <= expert_index_i;
      ok_q  <= op_ok_i;
    end
    if (state_q == S_SCAN) begin
      st_q   <= stv_q[e_id] ? ram_rdata : ST_UNLOADED;
      hit_q  <= c_match;
      cand_q <= c_cand;
    end
    if (state_q == S_PICK) begin
      sel_q <= (act_q == ACT_TRIM) ? (cand_q & (~cand_q + 1'b1)) : hit_q;
    end
    if (state_q == S_EXEC) begin
      code_q  <= code;
      load_q  <= load;
      evict_q <= evict;
      miss_q  <= miss;
      tgt_q   <= tgt;
    end
  end

  assign done_o           = done_q;
  assign status_code_o    = code_q;
  assign load_request_o   = load_q;
  assign evict_request_o  = evict_q;
  assign target_expert_o  = tgt_q;
  assign expert_miss_o    = miss_q;
  assign resident_count_o = CNT_W'(len_q);

endmodule

// ===== design/pler_chk.sv =====
// pler_chk: port-level checks of the pinned lru expert cache, bound to the top level
// depends on pler_pkg and pinned_lru_expert_cache
module pler_chk import pler_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [CODE_W-1:0] status_code_o,
  input logic              load_request_o,
  input logic              evict_request_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after a word");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o) else $error("result word missing");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  a_load_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && load_request_o) |-> ((status_code_o == RC_MISS) && !evict_request_o))
    else $error("load request with wrong code");

  a_evict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evict_request_o) |-> (status_code_o == RC_OK))
    else $error("evict request with wrong code");

endmodule

bind pinned_lru_expert_cache pler_chk u_pler_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_code_o   (status_code_o),
  .load_request_o  (load_request_o),
  .evict_request_o (evict_request_o)
);
